### design/bfp4q_pkg.sv
// ----------------------------------------------------------------------------
// bfp4q_pkg
// Types, constants and helpers for the BF16 to 4-bit block floating point
// group quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfp4q_pkg;

   localparam int unsigned GroupSize  = 16;
   localparam int unsigned ExpWidth   = 8;
   localparam int unsigned ManWidth   = 24;
   localparam int unsigned DropBits   = 21;
   localparam int unsigned MagWidth   = 3;
   localparam int unsigned NibWidth   = 4;
   localparam int unsigned ShiftLimit = 32;

   localparam logic [MagWidth-1:0] MagMax = 3'd7;

   typedef logic [15:0] bf16_type;

   typedef struct packed {
      logic [31:0] pair_7;
      logic [31:0] pair_6;
      logic [31:0] pair_5;
      logic [31:0] pair_4;
      logic [31:0] pair_3;
      logic [31:0] pair_2;
      logic [31:0] pair_1;
      logic [31:0] pair_0;
   } req_type;

   typedef struct packed {
      logic [7:0]  shared_exponent;
      logic [31:0] nibbles_low;
      logic [31:0] nibbles_high;
   } rsp_type;

   function automatic logic [ExpWidth-1:0] bf16_exp(input bf16_type value);
      return value[14:7];
   endfunction

endpackage

`default_nettype wire

### design/bf16_to_bfp4_group_quantizer_core.sv
// ----------------------------------------------------------------------------
// bf16_to_bfp4_group_quantizer_core
// Quantizes a group of sixteen BF16 values to 4-bit block floating point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one group of sixteen BF16 values packed in eight 32-bit
//   pairs. rsp_* returns the shared exponent and sixteen sign-magnitude
//   nibbles. Both channels are valid/ready.
//   A request accepted into the input register has its result loaded into the
//   output register at the next edge if that register is free or being drained,
//   so rsp_valid rises in the cycle after acceptance.
//   Throughput is one request per cycle while the receiver keeps taking
//   responses: the max tree and the sixteen encoders sit combinationally
//   between the two registers.
//   When the receiver stalls, the held result stays on rsp_payload and one
//   more request is still taken into the input register; req_ready then
//   drops until the output drains.
//   Reset clears both valid flags; no request is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module bf16_to_bfp4_group_quantizer_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire bfp4q_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output bfp4q_pkg::rsp_type   rsp_payload
);
   import bfp4q_pkg::*;

   logic     s1_valid_ff;
   logic     s1_valid_in;
   req_type  s1_data_ff;
   logic     out_valid_ff;
   logic     out_valid_in;
   rsp_type  out_data_ff;
   logic     s1_adv;
   bf16_type [15:0] elems;
   logic [7:0]      group_exp;
   logic [3:0]      nibs [16];
   rsp_type         result;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_payload;
      end
      if (s1_adv) begin
         out_data_ff <= result;
      end
   end

   assign elems = {s1_data_ff.pair_7, s1_data_ff.pair_6, s1_data_ff.pair_5,
                   s1_data_ff.pair_4, s1_data_ff.pair_3, s1_data_ff.pair_2,
                   s1_data_ff.pair_1, s1_data_ff.pair_0};

   bfp4q_max u_max (
      .elems   (elems),
      .max_exp (group_exp)
   );

   for (genvar i = 0; i < GroupSize; i++) begin : g_enc
      bfp4q_enc u_enc (
         .elem      (elems[i]),
         .group_exp (group_exp),
         .nibble    (nibs[i])
      );
   end

   always_comb begin
      result.shared_exponent = group_exp;
      for (int i = 0; i < 8; i++) begin
         result.nibbles_low[4*i +: 4]  = nibs[i];
         result.nibbles_high[4*i +: 4] = nibs[i+8];
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

`ifndef SYNTH
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !out_valid_ff))
      else $error("valid flags not cleared by reset");

   a_zero_exp_codes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.shared_exponent == 8'd0)) |->
      ((rsp_payload.nibbles_low == 32'd0) && (rsp_payload.nibbles_high == 32'd0)))
      else $error("nonzero code with zero shared exponent");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("advanced request lost before output register");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("request refused with empty input register");
`endif

endmodule

`default_nettype wire

### design/bfp4q_max.sv
// ----------------------------------------------------------------------------
// bfp4q_max
// Comparator tree that finds the largest biased exponent of a group.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp4q_max (
   input  wire bfp4q_pkg::bf16_type [15:0] elems,
   output logic [7:0]                      max_exp
);
   import bfp4q_pkg::*;

   logic [ExpWidth-1:0] lvl0 [16];
   logic [ExpWidth-1:0] lvl1 [8];
   logic [ExpWidth-1:0] lvl2 [4];
   logic [ExpWidth-1:0] lvl3 [2];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         lvl0[i] = bf16_exp(elems[i]);
      end
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = (lvl0[2*i] > lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = (lvl2[2*i] > lvl2[2*i+1]) ? lvl2[2*i] : lvl2[2*i+1];
      end
      max_exp = (lvl3[0] > lvl3[1]) ? lvl3[0] : lvl3[1];
   end

endmodule

`default_nettype wire

### design/bfp4q_enc.sv
// ----------------------------------------------------------------------------
// bfp4q_enc
// Aligns one BF16 value to the shared exponent and rounds it to a
// sign-magnitude nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp4q_enc (
   input  wire bfp4q_pkg::bf16_type elem,
   input  wire [7:0]                group_exp,
   output logic [3:0]               nibble
);
   import bfp4q_pkg::*;

   localparam logic [DropBits-1:0] Half = DropBits'(1) << (DropBits - 1);

   logic [ExpWidth-1:0] exp_val;
   logic [ExpWidth-1:0] shift_amt;
   logic [ManWidth-1:0] man;
   logic [ManWidth-1:0] man_sh;
   logic [DropBits-1:0] rem;
   logic [MagWidth-1:0] quo;
   logic                round_up;
   logic [MagWidth:0]   mag_rnd;
   logic [MagWidth-1:0] mag;

   always_comb begin
      exp_val   = bf16_exp(elem);
      man       = {1'b1, elem[6:0], 16'd0};
      shift_amt = (group_exp > exp_val) ? (group_exp - exp_val) : '0;
      man_sh    = (shift_amt >= ExpWidth'(ShiftLimit)) ? '0 : (man >> shift_amt[4:0]);
      rem       = man_sh[DropBits-1:0];
      quo       = man_sh[ManWidth-1:DropBits];
      round_up  = (rem > Half) || ((rem == Half) && quo[0]);
      mag_rnd   = {1'b0, quo} + {{MagWidth{1'b0}}, round_up};
      mag       = mag_rnd[MagWidth] ? MagMax : mag_rnd[MagWidth-1:0];
      if ((exp_val == '0) || (mag == '0)) begin
         nibble = '0;
      end else begin
         nibble = {elem[15], mag};
      end
   end

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the BF16 to 4-bit block floating point group quantizer.
// Directed groups cover zeros, subnormals, infinities and NaNs, rounding ties,
// saturation and long shifts. Random groups follow, with bursty requests and
// a stalling receiver. Every response is checked against a local model.
// ----------------------------------------------------------------------------

module tb;
   import bfp4q_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type pending_reqs[$];
   bit      pending_drain[$];
   rsp_type expected_rsps[$];
   rsp_type want;

   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int ready_left = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;
   int rsp_count = 0;
   int mismatch_count = 0;

   bf16_to_bfp4_group_quantizer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [3:0] bfp4_code(input bf16_type value, input logic [7:0] shared);
      logic [7:0]  e;
      logic [7:0]  shift_amt;
      logic [23:0] man;
      logic [20:0] rem;
      logic [3:0]  mag;
      e = value[14:7];
      if (e == 8'd0)
         return 4'd0;
      man = {1'b1, value[6:0], 16'h0000};
      shift_amt = shared - e;
      if (shift_amt >= ShiftLimit)
         man = '0;
      else
         man = man >> shift_amt;
      rem = man[DropBits-1:0];
      mag = {1'b0, man[23:21]};
      if (rem > 21'h100000 || (rem == 21'h100000 && mag[0]))
         mag = mag + 4'd1;
      if (mag > MagMax)
         mag = {1'b0, MagMax};
      if (mag == 4'd0)
         return 4'd0;
      return {value[15], mag[2:0]};
   endfunction

   function automatic rsp_type quantize_group(input req_type req);
      logic [255:0] flat;
      bf16_type     vals [GroupSize];
      logic [7:0]   shared;
      rsp_type      rsp;
      flat = req;
      shared = 8'd0;
      for (int i = 0; i < GroupSize; i++) begin
         vals[i] = flat[16*i +: 16];
         if (vals[i][14:7] > shared)
            shared = vals[i][14:7];
      end
      rsp.shared_exponent = shared;
      for (int i = 0; i < 8; i++) begin
         rsp.nibbles_low[4*i +: 4]  = bfp4_code(vals[i], shared);
         rsp.nibbles_high[4*i +: 4] = bfp4_code(vals[i+8], shared);
      end
      return rsp;
   endfunction

   function automatic bf16_type random_bf16(input logic [7:0] top);
      logic [7:0]  e;
      int unsigned pick;
      int unsigned offs;
      pick = $urandom_range(0, 19);
      offs = $urandom_range(0, 10);
      if (pick == 0)
         e = 8'd0;
      else if (pick == 1)
         e = 8'd255;
      else if (pick == 2)
         e = 8'($urandom_range(0, 255));
      else
         e = (top > offs) ? 8'(top - offs) : 8'd0;
      return {1'($urandom), e, 7'($urandom)};
   endfunction

   task automatic add_group(input req_type grp, input bit drain);
      pending_reqs.push_back(grp);
      pending_drain.push_back(drain);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(quantize_group(req_payload));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_drain[0] && expected_rsps.size() != 0)) begin
               req_valid <= 1'b1;
               req_payload <= pending_reqs.pop_front();
               void'(pending_drain.pop_front());
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                           : $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            rsp_count++;
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_count >= 300 && !holdoff_done) begin
            holdoff_done = 1'b1;
            holdoff_left = 99;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (ready_left != 0) begin
               ready_left--;
            end else begin
               ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                        : $urandom_range(0, 15);
               stall_left = $urandom_range(1, 6);
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.shared_exponent !== want.shared_exponent) begin
               $display("%0t shared_exponent expected %h actual %h", $time,
                        want.shared_exponent, rsp_payload.shared_exponent);
               mismatch_count++;
            end
            if (rsp_payload.nibbles_low !== want.nibbles_low) begin
               $display("%0t nibbles_low expected %h actual %h", $time,
                        want.nibbles_low, rsp_payload.nibbles_low);
               mismatch_count++;
            end
            if (rsp_payload.nibbles_high !== want.nibbles_high) begin
               $display("%0t nibbles_high expected %h actual %h", $time,
                        want.nibbles_high, rsp_payload.nibbles_high);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic [255:0] grp;
      logic [7:0]   top;

      // directed groups
      add_group({16{16'h0000}}, 1'b0);
      add_group({16{16'hFFFF}}, 1'b0);
      add_group({16{16'h7F80}}, 1'b0);
      add_group({16{16'h8000}}, 1'b0);
      grp = {16{16'h8001}};
      grp[15:0] = 16'h3F80;
      add_group(grp, 1'b0);
      add_group({16{16'h3F80}}, 1'b0);
      add_group({16{16'hBF80}}, 1'b0);
      add_group({16{16'h3FFF}}, 1'b0);
      // rounding ties: even stays, odd goes up
      add_group({8{16'hBFB0, 16'h3F90}}, 1'b0);
      // rounds to zero, rounds up to one
      grp = {8{16'hBE7F, 16'hBDFF}};
      grp[15:0] = 16'h3F80;
      add_group(grp, 1'b0);
      // long shifts
      grp = {4{16'h7000, 16'h6F80, 16'h0080, 16'h807F}};
      grp[15:0] = 16'h7F80;
      add_group(grp, 1'b0);
      grp = {4{16'h7000, 16'h6FFF, 16'h7F7F, 16'hFF7F}};
      grp[31:16] = 16'h7FC1;
      add_group(grp, 1'b0);
      grp = {16{16'h1234}};
      grp[255:240] = 16'hE47F;
      add_group(grp, 1'b0);
      grp = {16{16'h9ABC}};
      grp[143:128] = 16'h6455;
      add_group(grp, 1'b0);
      add_group({16{16'hAAAA}}, 1'b0);
      add_group({16{16'h5555}}, 1'b0);

      for (int n = 0; n < 950; n++) begin
         if ($urandom_range(0, 6) == 0) begin
            for (int i = 0; i < 8; i++)
               grp[32*i +: 32] = $urandom;
         end else begin
            top = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 254));
            for (int i = 0; i < GroupSize; i++)
               grp[16*i +: 16] = random_bf16(top);
         end
         add_group(grp, (n % 150) == 0);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
